### rtl/cbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbr_pkg - shared definitions for the in-place cross blur core
// Register codes, fade codes, field widths and the per-item control bundle.
// ----------------------------------------------------------------------------
package cbr_pkg;

  localparam int LINE_MAX_DEFAULT = 4096;
  localparam int CFG_W            = 13;
  localparam int CFG_INDEX_W      = 2;
  localparam int ROW_W            = 14;

  localparam logic [CFG_W-1:0] LINE_BYTES_RESET = 13'd48;
  localparam logic [CFG_W-1:0] FRAME_ROWS_RESET = 13'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_BYTES = 2'd0,
    REG_FRAME_ROWS = 2'd1,
    REG_FADE_MODE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FADE_NONE = 2'd0,
    FADE_UP   = 2'd1,
    FADE_DOWN = 2'd2
  } fade_t;

  // Decisions taken for one item at the moment it is accepted.
  typedef struct packed {
    logic emit;       // the item produces a blurred byte
    logic store;      // the item's down byte goes into the window
    logic done;       // the result is the final byte of the frame
    logic flushing;   // all frame bytes are in, the down neighbour is zero
    logic has_left;
    logic has_right;
    logic has_up;
  } cbr_ctl_t;

endpackage
`default_nettype wire

### rtl/cbr_position.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbr_position - raster position tracker
// Keeps column and row of the next item and decides what each item does.
// ----------------------------------------------------------------------------
module cbr_position #(
  parameter int LINE_MAX = cbr_pkg::LINE_MAX_DEFAULT
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 advance,
  input  wire                                 drain,
  input  wire [cbr_pkg::CFG_W-1:0]            line_bytes,
  input  wire [cbr_pkg::CFG_W-1:0]            frame_rows,
  output logic [$clog2(LINE_MAX+1)-1:0]       col,
  output logic [$clog2(LINE_MAX+1)-1:0]       len,
  output cbr_pkg::cbr_ctl_t                   ctl
);
  import cbr_pkg::*;

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  logic [CW-1:0]    column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [LW-1:0]    lb;
  logic [CFG_W-1:0] rows;
  logic [CW-1:0]    c_norm;
  logic [ROW_W-1:0] r_step, r_norm;
  logic [CW:0]      c_plus1;
  logic             ignore;

  always_comb begin
    lb = LW'(line_bytes);
    if (lb == '0) begin
      len = CW'(1);
    end else if (lb > LW'(LINE_MAX)) begin
      len = CW'(LINE_MAX);
    end else begin
      len = lb[CW-1:0];
    end
    rows = (frame_rows == '0) ? CFG_W'(1) : frame_rows;
  end

  // Bring the stored position back into range before using it.
  always_comb begin
    if (column_count >= len) begin
      c_norm = '0;
      r_step = row_count + ROW_W'(1);
    end else begin
      c_norm = column_count;
      r_step = row_count;
    end
    r_norm = r_step;
    if (r_step > ROW_W'(rows)) begin
      r_norm = '0;
      c_norm = '0;
    end
  end

  assign col = c_norm;

  always_comb begin
    ctl.flushing  = (r_norm >= ROW_W'(rows));
    ignore        = drain && !ctl.flushing;
    ctl.emit      = (r_norm != '0) && !ignore;
    ctl.done      = ctl.emit && ctl.flushing && (c_norm == len - CW'(1));
    ctl.store     = !ignore && !ctl.done;
    ctl.has_left  = (c_norm >= CW'(3));
    ctl.has_right = ((CW+1)'(c_norm) + (CW+1)'(3)) < (CW+1)'(len);
    ctl.has_up    = (r_norm >= ROW_W'(2));
  end

  always_comb begin
    c_plus1           = (CW+1)'(c_norm) + (CW+1)'(1);
    column_count_next = c_norm;
    row_count_next    = r_norm;
    if (ctl.done) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (ctl.store) begin
      if (c_plus1 >= (CW+1)'(len)) begin
        column_count_next = '0;
        row_count_next    = r_norm + ROW_W'(1);
      end else begin
        column_count_next = c_plus1[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule
`default_nettype wire

### rtl/cbr_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbr_window - ring of original bytes
// Holds the last LINE_MAX+4 original bytes and reads the centre, left and
// right neighbours one line back. Unwritten entries read as zero.
// ----------------------------------------------------------------------------
module cbr_window #(
  parameter int LINE_MAX = cbr_pkg::LINE_MAX_DEFAULT
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            rd_en,
  input  wire                            wr_en,
  input  wire [7:0]                      wr_data,
  input  wire [$clog2(LINE_MAX+1)-1:0]   len,
  output logic [7:0]                     centre,
  output logic [7:0]                     left,
  output logic [7:0]                     right
);
  import cbr_pkg::*;

  localparam int RING = LINE_MAX + 4;
  localparam int PW   = $clog2(RING);

  // Two copies so that three neighbours can be read in the same cycle.
  logic [7:0]    ring_a [RING];
  logic [7:0]    ring_b [RING];
  logic [PW-1:0] fill_count;
  logic          wrapped;
  logic [PW:0]   back_c, back_l, back_r;
  logic [PW-1:0] addr_c, addr_l, addr_r;
  logic [7:0]    centre_q, left_q, right_q;
  logic          ok_c, ok_l, ok_r;

  function automatic logic [PW-1:0] ring_addr(input logic [PW-1:0] fill,
                                              input logic [PW:0] back);
    logic [PW:0] sum;
    sum = {1'b0, fill} + (PW+1)'(RING) - back;
    if (sum >= (PW+1)'(RING)) begin
      sum = sum - (PW+1)'(RING);
    end
    return sum[PW-1:0];
  endfunction

  always_comb begin
    back_c = (PW+1)'(len);
    back_l = back_c + (PW+1)'(3);
    back_r = back_c - (PW+1)'(3);
    addr_c = ring_addr(fill_count, back_c);
    addr_l = ring_addr(fill_count, back_l);
    addr_r = ring_addr(fill_count, back_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_a[fill_count] <= wr_data;
      ring_b[fill_count] <= wr_data;
    end
    if (rd_en) begin
      centre_q <= ring_a[addr_c];
      left_q   <= ring_a[addr_l];
      right_q  <= ring_b[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      wrapped    <= 1'b0;
      ok_c       <= 1'b0;
      ok_l       <= 1'b0;
      ok_r       <= 1'b0;
    end else begin
      if (rd_en) begin
        ok_c <= wrapped || (addr_c < fill_count);
        ok_l <= wrapped || (addr_l < fill_count);
        ok_r <= wrapped || (addr_r < fill_count);
      end
      if (wr_en) begin
        if (fill_count == PW'(RING - 1)) begin
          fill_count <= '0;
          wrapped    <= 1'b1;
        end else begin
          fill_count <= fill_count + PW'(1);
        end
      end
    end
  end

  assign centre = ok_c ? centre_q : 8'd0;
  assign left   = ok_l ? left_q : 8'd0;
  assign right  = ok_r ? right_q : 8'd0;

endmodule
`default_nettype wire

### rtl/cbr_kernel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbr_kernel - five-point weighted average with optional fade
// Sums the cross neighbours and four times the centre, divides by eight.
// ----------------------------------------------------------------------------
module cbr_kernel (
  input  cbr_pkg::cbr_ctl_t ctl,
  input  wire [7:0]         centre,
  input  wire [7:0]         left,
  input  wire [7:0]         right,
  input  wire [7:0]         up,
  input  wire [7:0]         down,
  input  wire [1:0]         fade_mode,
  output logic [7:0]        res
);
  import cbr_pkg::*;

  logic [10:0] sum;
  logic [7:0]  avg;

  always_comb begin
    sum = {3'b000, down} + {1'b0, centre, 2'b00};
    if (ctl.has_left) begin
      sum = sum + {3'b000, left};
    end
    if (ctl.has_right) begin
      sum = sum + {3'b000, right};
    end
    if (ctl.has_up) begin
      sum = sum + {3'b000, up};
    end
    avg = sum[10:3];
    case (fade_mode)
      FADE_UP:   res = (avg == 8'hFF) ? avg : avg + 8'd1;
      FADE_DOWN: res = (avg == 8'h00) ? avg : avg - 8'd1;
      default:   res = avg;
    endcase
  end

endmodule
`default_nettype wire

### rtl/inplace_cross_blur_rgb24_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inplace_cross_blur_rgb24_core - streaming five-point blur of RGB24 frames
// Blurs every channel byte of a raster-order frame with its cross neighbours.
// ----------------------------------------------------------------------------
// The core takes one channel byte per clock while neither side stalls; items
// of the first line produce no result, so a frame of line_bytes * frame_rows
// bytes and line_bytes drain items give a result per frame byte. Each result
// is (up + down + left + right + 4 * centre) / 8, where left and right are the
// same channel one pixel away, down is the original byte of the next line and
// up is the blurred byte of the line above; neighbours outside the frame count
// as zero. Results trail the input by one line: the item at row r emits the
// byte of row r-1, and after the last frame byte the producer sends drain
// items (s_tuser high) to flush the final line, which ends with m_tlast high.
// A result passes through the second stage and the output register before it
// appears on m_tvalid. The original-byte ring and the blurred-line memory are
// each written at most once and read once per item, with registered read data.
// No clearing pass is needed after reset; a fill count makes unwritten ring
// entries read as zero, so items are taken from the first cycle out of reset.
// Configuration is written through cfg_we / cfg_index / cfg_data while no item
// is in flight; drain items that arrive while frame data is still expected are
// swallowed without effect.
// ----------------------------------------------------------------------------
module inplace_cross_blur_rgb24_core #(
  parameter int LINE_MAX = cbr_pkg::LINE_MAX_DEFAULT
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  input  wire [7:0]                       s_tdata,   // [7:0] pixel_byte
  input  wire                             s_tuser,   // [0] drain
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] blurred_byte
  output logic                            m_tlast,   // frame_done
  input  wire                             cfg_we,
  input  wire [cbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [cbr_pkg::CFG_W-1:0]        cfg_data
);
  import cbr_pkg::*;

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam int BW = $clog2(LINE_MAX);

  // Configuration registers.
  logic [CFG_W-1:0] line_bytes;
  logic [CFG_W-1:0] frame_rows;
  logic [1:0]       fade_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes <= LINE_BYTES_RESET;
      frame_rows <= FRAME_ROWS_RESET;
      fade_mode  <= FADE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_BYTES: line_bytes <= cfg_data;
        REG_FRAME_ROWS: frame_rows <= cfg_data;
        REG_FADE_MODE:  fade_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The second stage holds the memory read data; it moves into the
  // output register whenever that register is empty or being emptied.
  logic in_fire;
  logic out_load;
  logic s1_valid;

  assign out_load = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || out_load;
  assign in_fire  = s_tvalid && s_tready;

  // Position and per-item decisions, taken against the state before the item.
  logic [CW-1:0] col;
  logic [CW-1:0] len;
  cbr_ctl_t      ctl;
  logic [7:0]    down_next;

  cbr_position #(
    .LINE_MAX (LINE_MAX)
  ) u_position (
    .clk        (clk),
    .rst        (rst),
    .advance    (in_fire),
    .drain      (s_tuser),
    .line_bytes (line_bytes),
    .frame_rows (frame_rows),
    .col        (col),
    .len        (len),
    .ctl        (ctl)
  );

  // Once the frame's bytes are all in, the down neighbour is zero.
  assign down_next = ctl.flushing ? 8'd0 : s_tdata;

  logic [7:0] win_centre, win_left, win_right;

  cbr_window #(
    .LINE_MAX (LINE_MAX)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .wr_en   (in_fire && ctl.store),
    .wr_data (down_next),
    .len     (len),
    .centre  (win_centre),
    .left    (win_left),
    .right   (win_right)
  );

  // Second stage.
  cbr_ctl_t      s1_ctl;
  logic [CW-1:0] s1_col;
  logic [7:0]    s1_down;
  logic [7:0]    up_q;
  logic          fwd_hit;
  logic [7:0]    fwd_data;
  logic [7:0]    up_sel;
  logic [7:0]    res;

  // Blurred bytes of the previous line, written as results leave stage two.
  logic [7:0] blurred_line [LINE_MAX];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= ctl.emit;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl   <= ctl;
      s1_col   <= col;
      s1_down  <= down_next;
      // The result leaving stage two in this cycle is not yet in memory, so
      // a read of the same column takes it from here instead.
      fwd_hit  <= out_load && (s1_col == col);
      fwd_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      blurred_line[s1_col[BW-1:0]] <= res;
    end
    if (in_fire) begin
      up_q <= blurred_line[col[BW-1:0]];
    end
  end

  assign up_sel = fwd_hit ? fwd_data : up_q;

  cbr_kernel u_kernel (
    .ctl       (s1_ctl),
    .centre    (win_centre),
    .left      (win_left),
    .right     (win_right),
    .up        (up_sel),
    .down      (s1_down),
    .fade_mode (fade_mode),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res;
      m_tlast <= s1_ctl.done;
    end
  end

endmodule
`default_nettype wire
